/* hdl/kwm_pkg.sv */
// kwm_pkg: shared types and constants for the k-way sorted list merge
// no dependencies; used by kwm_cmp, the top level and the testbench

package kwm_pkg;

	localparam int DATA_W        = 32;
	localparam int DEF_MAX_TOTAL = 64;
	localparam int DEF_MAX_LISTS = 16;

	// one input beat
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     end_of_list;
		logic                     end_of_set;
	} in_beat_t;

	// one result beat
	typedef struct packed {
		logic signed [DATA_W-1:0] merged_value;
		logic                     last_out;
		logic                     overflow;
	} out_beat_t;

	// decision of the shared compare unit
	typedef struct packed {
		logic                     done;
		logic                     take_b;
		logic signed [DATA_W-1:0] pick_value;
	} pick_t;

endpackage

/* hdl/kwm_ram.sv */
// kwm_ram: generic single write port, single read port memory
// registered read data; no dependencies

module kwm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/kwm_cmp.sv */
// kwm_cmp: compare and select unit shared by every two-way merge step
// depends on kwm_pkg

module kwm_cmp import kwm_pkg::*; (
	input  logic signed [DATA_W-1:0] head_a,
	input  logic signed [DATA_W-1:0] head_b,
	input  logic                     a_empty,
	input  logic                     b_empty,
	output pick_t                    pick
);

	// on a tie the later list wins
	always_comb begin
		pick.done   = a_empty && b_empty;
		pick.take_b = a_empty || (!b_empty && (head_a >= head_b));
		pick.pick_value = pick.take_b ? head_b : head_a;
	end

endmodule

/* hdl/k_way_sorted_list_merge.sv */
// k_way_sorted_list_merge: top level, loads lists and folds them pairwise
// depends on kwm_pkg, kwm_ram, kwm_cmp
//
// channel   dir   handshake            beat contents
// in        in    in_valid/in_ready    value, end_of_list, end_of_set
// out       out   out_valid/out_ready  merged_value, last_out, overflow
//
// loading takes one beat per cycle; the end_of_set beat is taken and the
// block then drops in_ready until the last result beat is taken (a set
// holding no list leaves it loading). each merge round reads every
// element through the element ram and the shared compare unit, after
// reading the list lengths of each pair; rounds run ceil(log2(lists)) times.
// results leave one at a time, each captured only after the previous is taken.
// reset clears control only; the memories hold garbage until written and
// need no clearing pass. out_ready low simply holds the result register.

module k_way_sorted_list_merge import kwm_pkg::*; #(
	parameter int MAX_TOTAL = DEF_MAX_TOTAL,
	parameter int MAX_LISTS = DEF_MAX_LISTS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	localparam int AW  = (MAX_TOTAL > 1) ? $clog2(MAX_TOTAL) : 1;
	localparam int CW  = $clog2(MAX_TOTAL + 1);
	localparam int LIW = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
	localparam int LCW = $clog2(MAX_LISTS + 1);

	typedef enum logic [11:0] {
		S_LOAD      = 12'b0000_0000_0001,
		S_LEN_A     = 12'b0000_0000_0010,
		S_LEN_B     = 12'b0000_0000_0100,
		S_LEN_C     = 12'b0000_0000_1000,
		S_SETUP     = 12'b0000_0001_0000,
		S_RB        = 12'b0000_0010_0000,
		S_CAPB      = 12'b0000_0100_0000,
		S_PICK      = 12'b0000_1000_0000,
		S_CAPA      = 12'b0001_0000_0000,
		S_EMIT_RD   = 12'b0010_0000_0000,
		S_EMIT_CAP  = 12'b0100_0000_0000,
		S_EMIT_WAIT = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	// load counters; ecnt_q doubles as the total while merging
	logic [CW-1:0]  ecnt_q;
	logic [CW-1:0]  clen_q;
	logic [LCW-1:0] lcnt_q;
	logic           ovf_q;

	// merge walk: i from the front, j from the back
	logic [LIW-1:0] i_q;
	logic [LIW-1:0] j_q;
	logic [CW-1:0]  fp_q;   // start of list i in the source bank
	logic [CW-1:0]  bp_q;   // end of list j in the source bank
	logic [CW-1:0]  wp_q;   // write pointer in the destination bank
	logic [CW-1:0]  ra_q;   // next read of list a, also the result counter
	logic [CW-1:0]  rb_q;
	logic [CW-1:0]  ca_q;   // elements left in list a
	logic [CW-1:0]  cb_q;
	logic [CW-1:0]  la_q;
	logic [CW-1:0]  lb_q;
	logic signed [DATA_W-1:0] ha_q;
	logic signed [DATA_W-1:0] hb_q;
	logic           bank_q; // bank holding the current lists

	logic      out_valid_q;
	out_beat_t out_q;

	// ram ports
	logic              el_we;
	logic              el_wbank;
	logic [AW-1:0]     el_waddr;
	logic [DATA_W-1:0] el_wdata;
	logic [AW-1:0]     el_raddr;
	logic [DATA_W-1:0] el_rdata0;
	logic [DATA_W-1:0] el_rdata1;
	logic [DATA_W-1:0] el_rdata;
	logic              len_we;
	logic [LIW-1:0]    len_waddr;
	logic [CW-1:0]     len_wdata;
	logic [LIW-1:0]    len_raddr;
	logic [CW-1:0]     len_rdata;

	// load beat decode
	logic           in_fire;
	logic           full;
	logic [CW-1:0]  ecnt_n;
	logic [CW-1:0]  clen_n;
	logic           record;
	logic [LCW-1:0] lcnt_n;
	logic [LCW-1:0] lcnt_m1;

	// merge helpers
	pick_t          pick;
	logic [CW-1:0]  ra_inc;
	logic [CW-1:0]  rb_inc;
	logic [CW-1:0]  emit_last_idx;
	logic           round_end;

	assign in_ready  = (state_q == S_LOAD);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign full    = (lcnt_q == LCW'(MAX_LISTS)) || (ecnt_q == CW'(MAX_TOTAL));
	assign ecnt_n  = ecnt_q + CW'(!full);
	assign clen_n  = clen_q + CW'(!full);
	// a list made only of dropped elements is never recorded
	assign record  = (in_data.end_of_list || in_data.end_of_set) && (clen_n != '0)
	                 && (lcnt_q != LCW'(MAX_LISTS));
	assign lcnt_n  = lcnt_q + LCW'(record);
	assign lcnt_m1 = lcnt_n - LCW'(1);

	assign ra_inc        = ra_q + CW'(1);
	assign rb_inc        = rb_q + CW'(1);
	assign emit_last_idx = ecnt_q - CW'(1);
	// last pair of a round: lists meet or cross
	assign round_end     = (j_q == i_q) || (j_q == i_q + LIW'(1));

	assign el_rdata = bank_q ? el_rdata1 : el_rdata0;

	kwm_cmp u_cmp (
		.head_a  (ha_q),
		.head_b  (hb_q),
		.a_empty (ca_q == '0),
		.b_empty (cb_q == '0),
		.pick    (pick)
	);

	kwm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TOTAL)) u_bank0 (
		.clk   (clk),
		.we    (el_we && !el_wbank),
		.waddr (el_waddr),
		.wdata (el_wdata),
		.raddr (el_raddr),
		.rdata (el_rdata0)
	);

	kwm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TOTAL)) u_bank1 (
		.clk   (clk),
		.we    (el_we && el_wbank),
		.waddr (el_waddr),
		.wdata (el_wdata),
		.raddr (el_raddr),
		.rdata (el_rdata1)
	);

	kwm_ram #(.WIDTH(CW), .DEPTH(MAX_LISTS)) u_len (
		.clk   (clk),
		.we    (len_we),
		.waddr (len_waddr),
		.wdata (len_wdata),
		.raddr (len_raddr),
		.rdata (len_rdata)
	);

	// ram write and read steering
	always_comb begin
		el_we     = 1'b0;
		el_wbank  = bank_q;
		el_waddr  = ecnt_q[AW-1:0];
		el_wdata  = in_data.value;
		len_we    = 1'b0;
		len_waddr = lcnt_q[LIW-1:0];
		len_wdata = clen_n;
		len_raddr = i_q;
		el_raddr  = ra_q[AW-1:0];

		unique case (state_q) inside
			S_LOAD: begin
				el_we  = in_fire && !full;
				len_we = in_fire && record;
			end
			S_LEN_B: begin
				len_raddr = j_q;
			end
			S_SETUP: begin
				el_raddr = fp_q[AW-1:0];
			end
			S_RB: begin
				el_raddr = rb_q[AW-1:0];
			end
			S_PICK: begin
				// merged element goes to the other bank
				el_we     = !pick.done;
				el_wbank  = !bank_q;
				el_waddr  = wp_q[AW-1:0];
				el_wdata  = pick.pick_value;
				// merged list takes the place of list i
				len_we    = pick.done;
				len_waddr = i_q;
				len_wdata = la_q + lb_q;
				el_raddr  = pick.take_b ? rb_inc[AW-1:0] : ra_inc[AW-1:0];
			end
			S_EMIT_WAIT: begin
				el_raddr = ra_inc[AW-1:0];
			end
			S_LEN_A, S_LEN_C, S_CAPB, S_CAPA, S_EMIT_RD, S_EMIT_CAP: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			ecnt_q      <= '0;
			clen_q      <= '0;
			lcnt_q      <= '0;
			ovf_q       <= 1'b0;
			bank_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_fire) begin
						if (in_data.end_of_set) begin
							lcnt_q <= '0;
							clen_q <= '0;
							if (lcnt_n == '0) begin
								ecnt_q <= '0;
								ovf_q  <= 1'b0;
							end else begin
								ecnt_q <= ecnt_n;
								ovf_q  <= ovf_q || full;
								ra_q   <= '0;
								i_q    <= '0;
								j_q    <= lcnt_m1[LIW-1:0];
								fp_q   <= '0;
								bp_q   <= ecnt_n;
								wp_q   <= '0;
								// a single list goes straight out
								state_q <= (lcnt_n == LCW'(1)) ? S_EMIT_RD : S_LEN_A;
							end
						end else begin
							ecnt_q <= ecnt_n;
							ovf_q  <= ovf_q || full;
							lcnt_q <= lcnt_n;
							clen_q <= (in_data.end_of_list) ? '0 : clen_n;
						end
					end
				end
				S_LEN_A: begin
					state_q <= S_LEN_B;
				end
				S_LEN_B: begin
					la_q <= len_rdata;
					if (i_q == j_q) begin
						// middle list of an odd count: merge against nothing
						lb_q    <= '0;
						state_q <= S_SETUP;
					end else begin
						state_q <= S_LEN_C;
					end
				end
				S_LEN_C: begin
					lb_q    <= len_rdata;
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					ra_q    <= fp_q;
					ca_q    <= la_q;
					rb_q    <= bp_q - lb_q;
					cb_q    <= lb_q;
					state_q <= S_RB;
				end
				S_RB: begin
					ha_q    <= $signed(el_rdata);
					state_q <= S_CAPB;
				end
				S_CAPB: begin
					hb_q    <= $signed(el_rdata);
					state_q <= S_PICK;
				end
				S_CAPA: begin
					ha_q    <= $signed(el_rdata);
					state_q <= S_PICK;
				end
				S_PICK: begin
					if (!pick.done) begin
						wp_q <= wp_q + CW'(1);
						if (pick.take_b) begin
							rb_q    <= rb_inc;
							cb_q    <= cb_q - CW'(1);
							state_q <= S_CAPB;
						end else begin
							ra_q    <= ra_inc;
							ca_q    <= ca_q - CW'(1);
							state_q <= S_CAPA;
						end
					end else if (!round_end) begin
						// next pair of this round
						fp_q    <= fp_q + la_q;
						bp_q    <= bp_q - lb_q;
						i_q     <= i_q + LIW'(1);
						j_q     <= j_q - LIW'(1);
						state_q <= S_LEN_A;
					end else begin
						// round done; list i was the last one written
						bank_q <= !bank_q;
						fp_q   <= '0;
						bp_q   <= ecnt_q;
						wp_q   <= '0;
						i_q    <= '0;
						j_q    <= i_q;
						ra_q   <= '0;
						state_q <= (i_q == '0) ? S_EMIT_RD : S_LEN_A;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_CAP;
				end
				S_EMIT_CAP: begin
					out_q.merged_value <= $signed(el_rdata);
					out_q.last_out     <= (ra_q == emit_last_idx);
					out_q.overflow     <= ovf_q;
					out_valid_q        <= 1'b1;
					state_q            <= S_EMIT_WAIT;
				end
				S_EMIT_WAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (out_q.last_out) begin
							ecnt_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							ra_q    <= ra_inc;
							state_q <= S_EMIT_CAP;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// a result beat is only ever presented from the wait state
	a_out_only_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == S_EMIT_WAIT))
		else $error("result valid outside emit wait");

	// loading and emitting never overlap
	a_no_load_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is pending");

	// the merge never writes past the number of stored elements
	a_wp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PICK) |-> (wp_q <= ecnt_q))
		else $error("merge write pointer beyond element count");

	// taking the final result returns the block to loading
	a_last_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_data.last_out) |=> in_ready)
		else $error("block not ready after last result");
`endif

endmodule

/* tb/kwm_merge_checker.sv */
// kwm_merge_checker: watches both beat channels of the k-way merge, predicts
// the merged output of every set and compares it beat by beat
// depends on kwm_pkg only

module kwm_merge_checker import kwm_pkg::*; #(
	parameter int MAX_TOTAL = DEF_MAX_TOTAL,
	parameter int MAX_LISTS = DEF_MAX_LISTS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_beat_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_beat_t out_data,
	output int        pending,
	output int        failures
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [DATA_W-1:0] word_t;

	// predictor copy of the set being loaded
	word_t     stash [MAX_TOTAL];
	int        run_base [MAX_LISTS];
	int        run_len [MAX_LISTS];
	int        n_runs   = 0;
	int        n_stored = 0;
	int        open_len = 0;
	bit        dropped  = 1'b0;
	out_beat_t merged_due [$];
	int        bad = 0;

	// pairwise rounds: list i with list top-i, ties go to the later list
	function automatic void fold_lists();
		word_t tmp [MAX_TOTAL];
		int    top, lo, hi, wr, a, b, ea, eb, k;
		top = n_runs - 1;
		while (top != 0) begin
			lo = 0;
			hi = top;
			wr = 0;
			while (lo < hi) begin
				a  = run_base[lo];
				ea = a + run_len[lo];
				b  = run_base[hi];
				eb = b + run_len[hi];
				run_base[lo] = wr;
				run_len[lo]  = run_len[lo] + run_len[hi];
				while (a < ea || b < eb) begin
					if (b < eb && (a >= ea || stash[a] >= stash[b])) begin
						tmp[wr] = stash[b];
						b++;
					end else begin
						tmp[wr] = stash[a];
						a++;
					end
					wr++;
				end
				lo++;
				hi--;
			end
			// odd count: middle list carried over untouched
			if (lo == hi) begin
				for (k = 0; k < run_len[lo]; k++)
					tmp[wr + k] = stash[run_base[lo] + k];
				run_base[lo] = wr;
				wr += run_len[lo];
			end
			for (k = 0; k < wr; k++)
				stash[k] = tmp[k];
			top = hi;
		end
	endfunction

	function automatic void load_element(input in_beat_t b);
		out_beat_t r;
		int        k;
		if (n_runs >= MAX_LISTS || n_stored >= MAX_TOTAL) begin
			dropped = 1'b1;
		end else begin
			stash[n_stored] = b.value;
			n_stored++;
			open_len++;
		end
		if (b.end_of_list || b.end_of_set) begin
			if (open_len > 0 && n_runs < MAX_LISTS) begin
				run_base[n_runs] = n_stored - open_len;
				run_len[n_runs]  = open_len;
				n_runs++;
			end
			open_len = 0;
		end
		if (b.end_of_set) begin
			if (n_runs > 0) begin
				fold_lists();
				for (k = 0; k < run_len[0]; k++) begin
					r.merged_value = stash[run_base[0] + k];
					r.last_out     = (k == run_len[0] - 1);
					r.overflow     = dropped;
					merged_due     = {merged_due, r};
				end
			end
			n_runs   = 0;
			n_stored = 0;
			open_len = 0;
			dropped  = 1'b0;
		end
	endfunction

	task automatic flag_bad(input string what, input out_beat_t want, input out_beat_t got);
		bad++;
		if (bad <= 10)
			$display("%0t: %s: expected %0d last %0b ovf %0b, got %0d last %0b ovf %0b",
				$time, what, want.merged_value, want.last_out, want.overflow,
				got.merged_value, got.last_out, got.overflow);
	endtask

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				load_element(in_data);
			if (out_valid && out_ready) begin
				if (merged_due.size() == 0) begin
					flag_bad("result beat with none due", '0, out_data);
				end else begin
					want = merged_due.pop_front();
					if (out_data.merged_value !== want.merged_value ||
					    out_data.last_out !== want.last_out ||
					    out_data.overflow !== want.overflow)
						flag_bad("result beat mismatch", want, out_data);
				end
			end
		end
		pending  <= merged_due.size();
		failures <= bad;
	end

endmodule

/* tb/tb_k_way_sorted_list_merge.sv */
// tb_k_way_sorted_list_merge: stimulus and verdict for the k-way merge
// depends on kwm_pkg, k_way_sorted_list_merge and kwm_merge_checker

module tb_k_way_sorted_list_merge import kwm_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [DATA_W-1:0] word_t;

	// shapes of a random set
	typedef enum int {
		SET_PLAIN,
		SET_UNORDERED,
		SET_FULL_STORE,
		SET_MANY_LISTS
	} set_kind_t;

	localparam int MAX_LISTS_TB = DEF_MAX_LISTS;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	in_beat_t  in_data   = '0;
	logic      out_ready = 1'b0;
	logic      in_ready;
	logic      out_valid;
	out_beat_t out_data;
	int        pending;
	int        failures;

	// calm turns off idling on both sides; hold_req asks the receiver for a long stall
	bit        calm     = 1'b0;
	bit        hold_req = 1'b0;
	int        n_beats    = 0;
	int        n_sets     = 0;
	int        n_ovf_sets = 0;
	in_beat_t  pile [$];

	always #6 clk = ~clk;

	k_way_sorted_list_merge u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	kwm_merge_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.pending   (pending),
		.failures  (failures)
	);

	// full 32-bit range, or a tight band so lists interleave and tie often
	function automatic word_t pick_value(input bit tight);
		if (tight)
			return word_t'($urandom_range(0, 12)) - 6;
		return word_t'($urandom);
	endfunction

	function automatic void put(input word_t v, input bit eol, input bit eos);
		in_beat_t b;
		b.value       = v;
		b.end_of_list = eol;
		b.end_of_set  = eos;
		pile = {pile, b};
	endfunction

	function automatic void add_list(input int len, input bit ordered, input bit tight);
		word_t vals [$];
		int    k;
		for (k = 0; k < len; k++)
			vals = {vals, pick_value(tight)};
		if (ordered)
			vals.sort();
		for (k = 0; k < len; k++)
			put(vals[k], k == len - 1, 1'b0);
	endfunction

	function automatic void shape_set(input set_kind_t kind);
		int lists, most, k;
		bit tight;
		tight = $urandom_range(1);
		case (kind) inside
			SET_PLAIN, SET_UNORDERED: begin
				lists = $urandom_range(1, MAX_LISTS_TB);
				most  = DEF_MAX_TOTAL / lists;
				if (most > 8)
					most = 8;
				for (k = 0; k < lists; k++)
					add_list($urandom_range(1, most), kind == SET_PLAIN, tight);
			end
			// more elements than the store holds
			SET_FULL_STORE: begin
				lists = $urandom_range(3, 5);
				for (k = 0; k < lists; k++)
					add_list($urandom_range(22, 30), 1'b1, tight);
			end
			// more lists than the block can track
			default: begin
				lists = $urandom_range(DEF_MAX_LISTS + 1, DEF_MAX_LISTS + 6);
				for (k = 0; k < lists; k++)
					add_list($urandom_range(1, 3), 1'b1, tight);
			end
		endcase
		// the set closes on its last beat, with or without its own end of list
		pile[pile.size() - 1].end_of_set  = 1'b1;
		pile[pile.size() - 1].end_of_list = $urandom_range(1);
	endfunction

	// valid goes up at a clock edge and stays up until the beat is taken
	task automatic send_beat(input in_beat_t b);
		while (!calm && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic send_pile();
		int k;
		for (k = 0; k < pile.size(); k++) begin
			send_beat(pile[k]);
			n_beats++;
			if (pile[k].end_of_set)
				n_sets++;
		end
		pile.delete();
	endtask

	// sender stops offering until every predicted result beat is out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// receiver: random backpressure, plus one long stall on request
	initial begin
		int hold_left;
		hold_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = 1500;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 18);
			end
		end
	end

	// stimulus and verdict
	initial begin
		set_kind_t kind;
		int        r, set_idx, first_random;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single element set at the top of the range
		put(32'sh7fffffff, 1'b1, 1'b1);
		// end of set without end of list, bottom of the range
		put(32'sh80000000, 1'b0, 1'b1);
		// four lists: extremes, ties across lists, an unsorted list, open last list
		put(32'sh80000000, 1'b0, 1'b0);
		put(-1, 1'b0, 1'b0);
		put(0, 1'b0, 1'b0);
		put(32'sh7fffffff, 1'b1, 1'b0);
		put(-1, 1'b0, 1'b0);
		put(0, 1'b0, 1'b0);
		put(0, 1'b1, 1'b0);
		put(3, 1'b0, 1'b0);
		put(-5, 1'b1, 1'b0);
		put(0, 1'b0, 1'b1);
		// three single-element lists that all tie
		put(5, 1'b1, 1'b0);
		put(5, 1'b1, 1'b0);
		put(5, 1'b1, 1'b1);
		send_pile();
		drain();

		first_random = n_beats;
		set_idx = 0;
		while (n_beats - first_random < 380) begin
			r = $urandom_range(99);
			if (r < 70)
				kind = SET_PLAIN;
			else if (r < 82)
				kind = SET_UNORDERED;
			else if (r < 91)
				kind = SET_FULL_STORE;
			else
				kind = SET_MANY_LISTS;
			// make sure both capacity limits are hit early
			if (set_idx == 0)
				kind = SET_MANY_LISTS;
			else if (set_idx == 1)
				kind = SET_FULL_STORE;
			else if (set_idx == 2)
				kind = SET_PLAIN;
			if (kind == SET_FULL_STORE || kind == SET_MANY_LISTS)
				n_ovf_sets++;
			// long output stall while the next set keeps being offered
			if (set_idx == 2)
				hold_req = 1'b1;
			calm = (set_idx >= 6 && set_idx < 9);
			shape_set(kind);
			send_pile();
			if (set_idx % 5 == 4)
				drain();
			set_idx++;
		end
		calm = 1'b0;

		drain();
		repeat (40) @(posedge clk);

		$display("covered %0d input beats in %0d sets, %0d random sets past capacity",
			n_beats, n_sets, n_ovf_sets);
		if (failures == 0)
			$display("[k_way_sorted_list_merge] OK");
		else
			$display("[k_way_sorted_list_merge] ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("timeout with %0d result beats still due", pending);
		$display("[k_way_sorted_list_merge] ERROR");
		$finish;
	end

endmodule

/* filelist.f */
hdl/kwm_pkg.sv
hdl/kwm_ram.sv
hdl/kwm_cmp.sv
hdl/k_way_sorted_list_merge.sv
tb/kwm_merge_checker.sv
tb/tb_k_way_sorted_list_merge.sv
